@@ hw/rtl/tcc_pkg.sv @@
package tcc_pkg;

  localparam int unsigned MAX_NODES_DEF  = 64;
  localparam int unsigned ROW_W          = 64;
  localparam int unsigned CNT_W          = 7;
  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIV_RD,
    ST_PIV_LAT,
    ST_ROW,
    ST_CHECK,
    ST_DONE
  } step_t;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_RD_PIVOT,
    OP_LAT_PIVOT,
    OP_ROW,
    OP_CHECK,
    OP_DONE
  } op_t;

  typedef enum logic [2:0] {
    J_NEVER,
    J_ALWAYS,
    J_START_LAST,
    J_K_DONE,
    J_I_DONE
  } jcond_t;

  typedef struct packed {
    op_t    op;
    jcond_t cond;
    step_t  target;
    logic   hold;
  } ucode_t;

  function automatic ucode_t ucode(input step_t step);
    ucode_t w;
    unique case (step)
      ST_IDLE:    w = '{op: OP_LOAD,      cond: J_START_LAST, target: ST_PIV_RD, hold: 1'b1};
      ST_PIV_RD:  w = '{op: OP_RD_PIVOT,  cond: J_K_DONE,     target: ST_CHECK,  hold: 1'b0};
      ST_PIV_LAT: w = '{op: OP_LAT_PIVOT, cond: J_NEVER,      target: ST_IDLE,   hold: 1'b0};
      ST_ROW:     w = '{op: OP_ROW,       cond: J_I_DONE,     target: ST_PIV_RD, hold: 1'b1};
      ST_CHECK:   w = '{op: OP_CHECK,     cond: J_I_DONE,     target: ST_DONE,   hold: 1'b1};
      ST_DONE:    w = '{op: OP_DONE,      cond: J_ALWAYS,     target: ST_IDLE,   hold: 1'b0};
      default:    w = '{op: OP_DONE,      cond: J_ALWAYS,     target: ST_IDLE,   hold: 1'b0};
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/transitive_closure_cycle_check.sv @@
// Acyclicity check of a directed graph by Warshall transitive closure.
// Input channel: start/busy. A row beat is taken at a clock edge with start
// high and busy low; in_row_bits is the adjacency row of the next node, in
// row order from node 0, one beat per cycle. in_last_row marks the final row.
// Rows after MAX_NODES rows are dropped; rows never sent read as zero.
// Config channel: cfg_valid/cfg_ready (always ready) writes cfg_node_count,
// the node count n (values above MAX_NODES act as MAX_NODES). Write only
// while idle.
// After the last row busy goes high while a microcoded sequencer drives one
// matrix RAM port pair: per pivot a pivot read, a latch and then one row
// read-modify-write per cycle, then a pivot read that leaves the pivot loop,
// the diagonal check of every row and the result strobe. The next row beat
// can be taken in the cycle after the result.
// out_valid is high for one cycle with out_acyclic; the receiver cannot
// stall. The matrix is then cleared at once through per-row valid bits.
// Reset: synchronous, rst_n low; clears the matrix, load position, and sets
// the node count to 64.
module transitive_closure_cycle_check #(
  parameter int unsigned MAX_NODES = tcc_pkg::MAX_NODES_DEF,
  localparam int unsigned AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
  localparam int unsigned CW = $clog2(MAX_NODES + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [tcc_pkg::ROW_W-1:0] in_row_bits,
  input  logic                      in_last_row,
  output logic                      out_valid,
  output logic                      out_acyclic,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [tcc_pkg::CNT_W-1:0] cfg_node_count
);

  localparam logic [CW-1:0] MAXN = CW'(MAX_NODES);

  tcc_pkg::step_t  step_r, step_nxt;
  tcc_pkg::ucode_t uw;

  logic [tcc_pkg::CNT_W-1:0] node_count_r;
  logic [CW-1:0]             load_idx_r, load_idx_nxt;
  logic [CW-1:0]             n_r, n_nxt;
  logic [tcc_pkg::ROW_W-1:0] mask_r, mask_nxt;
  logic [CW-1:0]             k_r, k_nxt;
  logic [CW-1:0]             i_r, i_nxt;
  logic [AW-1:0]             prev_r, prev_nxt;
  logic                      pend_r, pend_nxt;
  logic                      acyc_r, acyc_nxt;
  logic [tcc_pkg::ROW_W-1:0] pivot_r, pivot_nxt;
  logic [MAX_NODES-1:0]      valid_r, valid_nxt;
  logic                      rd_vld_r;

  logic                      accept;
  logic                      jump;
  logic                      k_done, i_done;
  logic [CW-1:0]             n_cfg;
  logic                      we;
  logic [AW-1:0]             waddr, raddr;
  logic [tcc_pkg::ROW_W-1:0] wdata, rdata, row_cur, row_k, row_p;

  assign uw     = tcc_pkg::ucode(step_r);
  assign busy   = (step_r != tcc_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign k_done = (k_r >= n_r);
  assign i_done = (i_r >= n_r);
  assign cfg_ready = 1'b1;

  assign n_cfg = (node_count_r > tcc_pkg::CNT_W'(MAX_NODES)) ? MAXN
                                                               : CW'(node_count_r);

  assign row_cur = rd_vld_r ? (rdata & mask_r) : '0;
  assign row_k   = row_cur >> k_r;
  assign row_p   = row_cur >> prev_r;

  tcc_ram #(
    .WIDTH (tcc_pkg::ROW_W),
    .DEPTH (MAX_NODES)
  ) u_mat (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // sequencer
  always_comb begin
    unique case (uw.cond)
      tcc_pkg::J_NEVER:      jump = 1'b0;
      tcc_pkg::J_ALWAYS:     jump = 1'b1;
      tcc_pkg::J_START_LAST: jump = accept && in_last_row;
      tcc_pkg::J_K_DONE:     jump = k_done;
      tcc_pkg::J_I_DONE:     jump = i_done;
      default:               jump = 1'b1;
    endcase
    priority if (jump) begin
      step_nxt = uw.target;
    end else if (uw.hold) begin
      step_nxt = step_r;
    end else begin
      step_nxt = tcc_pkg::step_t'(step_r + 3'd1);
    end
  end

  // datapath control
  always_comb begin
    load_idx_nxt = load_idx_r;
    n_nxt        = n_r;
    mask_nxt     = mask_r;
    k_nxt        = k_r;
    i_nxt        = i_r;
    prev_nxt     = prev_r;
    pend_nxt     = pend_r;
    acyc_nxt     = acyc_r;
    pivot_nxt    = pivot_r;
    valid_nxt    = valid_r;
    we           = 1'b0;
    waddr        = prev_r;
    wdata        = row_cur | pivot_r;
    raddr        = i_r[AW-1:0];
    out_valid    = 1'b0;
    unique case (uw.op)
      tcc_pkg::OP_LOAD: begin
        waddr = load_idx_r[AW-1:0];
        wdata = in_row_bits;
        if (accept) begin
          if (load_idx_r < MAXN) begin
            we = 1'b1;
            valid_nxt[load_idx_r[AW-1:0]] = 1'b1;
            load_idx_nxt = load_idx_r + CW'(1);
          end
          if (in_last_row) begin
            n_nxt    = n_cfg;
            mask_nxt = ~({tcc_pkg::ROW_W{1'b1}} << n_cfg);
            k_nxt    = '0;
            acyc_nxt = 1'b1;
          end
        end
      end
      tcc_pkg::OP_RD_PIVOT: begin
        raddr    = k_r[AW-1:0];
        i_nxt    = '0;
        pend_nxt = 1'b0;
      end
      tcc_pkg::OP_LAT_PIVOT: begin
        pivot_nxt = row_cur;
      end
      tcc_pkg::OP_ROW: begin
        if (pend_r && row_k[0]) begin
          we = 1'b1;
          valid_nxt[prev_r] = 1'b1;
        end
        if (!i_done) begin
          prev_nxt = i_r[AW-1:0];
          i_nxt    = i_r + CW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          k_nxt    = k_r + CW'(1);
        end
      end
      tcc_pkg::OP_CHECK: begin
        if (pend_r && row_p[0]) begin
          acyc_nxt = 1'b0;
        end
        if (!i_done) begin
          prev_nxt = i_r[AW-1:0];
          i_nxt    = i_r + CW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
      end
      tcc_pkg::OP_DONE: begin
        out_valid    = 1'b1;
        valid_nxt    = '0;
        load_idx_nxt = '0;
      end
      default: begin
        out_valid = 1'b0;
      end
    endcase
  end

  assign out_acyclic = acyc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= tcc_pkg::ST_IDLE;
      node_count_r <= tcc_pkg::NODE_COUNT_RST;
      load_idx_r   <= '0;
      valid_r      <= '0;
      pend_r       <= 1'b0;
      rd_vld_r     <= 1'b0;
    end else begin
      step_r     <= step_nxt;
      load_idx_r <= load_idx_nxt;
      valid_r    <= valid_nxt;
      pend_r     <= pend_nxt;
      rd_vld_r   <= valid_r[raddr];
      if (cfg_valid && cfg_ready) begin
        node_count_r <= cfg_node_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    mask_r  <= mask_nxt;
    k_r     <= k_nxt;
    i_r     <= i_nxt;
    prev_r  <= prev_nxt;
    acyc_r  <= acyc_nxt;
    pivot_r <= pivot_nxt;
  end

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside a closure run");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result not followed by idle");

  a_plain_row: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_last_row) |=> !busy && !out_valid)
    else $error("non-final row started a run");

endmodule

@@ hw/rtl/tcc_ram.sv @@
module tcc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
